// File: rtl/spf_pkg.sv
// Package for the smoothed pose follower: word types, register indexes and constants.
// Used by the top level, spf_lane and the testbench; depends on nothing.
package spf_pkg;

  typedef struct packed {
    logic signed [31:0] target_pos_x;
    logic signed [31:0] target_pos_y;
    logic signed [31:0] target_pos_z;
    logic signed [15:0] target_dir_x;
    logic signed [15:0] target_dir_y;
    logic signed [15:0] target_dir_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] light_pos_x;
    logic signed [31:0] light_pos_y;
    logic signed [31:0] light_pos_z;
    logic signed [15:0] light_dir_x;
    logic signed [15:0] light_dir_y;
    logic signed [15:0] light_dir_z;
  } out_word_t;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegFollowEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPositionGain = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDirectionGain = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMinLength = 2'd3;

  localparam logic [15:0] PosGainReset = 16'd4719;
  localparam logic [15:0] DirGainReset = 16'd3670;
  localparam logic [14:0] MinLenReset = 15'd16;

  localparam logic signed [31:0] PosXReset = 32'sd0;
  localparam logic signed [31:0] PosYReset = 32'sd327680;
  localparam logic signed [31:0] PosZReset = -32'sd131072;
  localparam logic signed [15:0] DirXReset = 16'sd0;
  localparam logic signed [15:0] DirYReset = -16'sd16384;
  localparam logic signed [15:0] DirZReset = 16'sd4915;

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic filt;
    logic div_start;
  } lane_ctrl_t;

endpackage

// File: rtl/smoothed_pose_follower_unit.sv
// Top level of the smoothed pose follower: config registers, state, sequencer.
// One word at a time, with the direction normalized when it is long enough; the
// next word is accepted in the cycle after the result leaves, and output stalls
// hold it back.
// Most of the work is the 17-step square root and the 32-step lane dividers.
// Reset (async, active low) restores default gains and the initial pose.
// Depends on spf_pkg, spf_lane and spf_merge.
module smoothed_pose_follower_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spf_pkg::in_word_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spf_pkg::out_word_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [spf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle, StFilt, StSqrt, StDiv, StOut
  } state_e;

  state_e state_q;
  logic   en_q;
  logic [15:0] pgain_q, dgain_q;
  logic [14:0] minlen_q;
  logic signed [31:0] pos_q [3];
  logic signed [15:0] dir_q [3];
  spf_pkg::in_word_t in_q;
  logic signed [31:0] tgt_pos [3];
  logic signed [15:0] tgt_dir [3];
  logic signed [31:0] pos_new [3];
  logic signed [15:0] dir_filt [3];
  logic signed [15:0] dir_norm [3];
  logic [2:0] div_done;
  spf_pkg::lane_ctrl_t ctrl;
  logic big, sq_done;
  logic [16:0] len;
  logic accept;
  logic ctrl_sq_start, sq_started_q;

  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign tgt_pos[0] = in_q.target_pos_x;
  assign tgt_pos[1] = in_q.target_pos_y;
  assign tgt_pos[2] = in_q.target_pos_z;
  assign tgt_dir[0] = in_q.target_dir_x;
  assign tgt_dir[1] = in_q.target_dir_y;
  assign tgt_dir[2] = in_q.target_dir_z;

  assign ctrl.filt = (state_q == StFilt);
  assign ctrl.div_start = (state_q == StSqrt) && sq_done && big;
  assign ctrl_sq_start = (state_q == StSqrt) && !sq_started_q;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    spf_lane u_lane (
      .clk_i, .rst_ni, .ctrl_i(ctrl),
      .pos_cur_i(pos_q[g]), .pos_tgt_i(tgt_pos[g]),
      .dir_cur_i(dir_q[g]), .dir_tgt_i(tgt_dir[g]),
      .pos_gain_i(pgain_q), .dir_gain_i(dgain_q), .len_i(len),
      .pos_new_o(pos_new[g]), .dir_filt_o(dir_filt[g]),
      .dir_norm_o(dir_norm[g]), .div_done_o(div_done[g])
    );
  end

  spf_merge u_merge (
    .clk_i, .rst_ni, .start_i(ctrl_sq_start),
    .dx_i(dir_filt[0]), .dy_i(dir_filt[1]), .dz_i(dir_filt[2]),
    .min_len_i(minlen_q), .big_o(big), .len_o(len), .done_o(sq_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sq_started_q <= 1'b0;
      out_valid_o <= 1'b0;
      en_q <= 1'b1;
      pgain_q <= spf_pkg::PosGainReset;
      dgain_q <= spf_pkg::DirGainReset;
      minlen_q <= spf_pkg::MinLenReset;
      pos_q[0] <= spf_pkg::PosXReset;
      pos_q[1] <= spf_pkg::PosYReset;
      pos_q[2] <= spf_pkg::PosZReset;
      dir_q[0] <= spf_pkg::DirXReset;
      dir_q[1] <= spf_pkg::DirYReset;
      dir_q[2] <= spf_pkg::DirZReset;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          spf_pkg::RegFollowEnable:  en_q <= cfg_data_i[0];
          spf_pkg::RegPositionGain:  pgain_q <= cfg_data_i;
          spf_pkg::RegDirectionGain: dgain_q <= cfg_data_i;
          spf_pkg::RegMinLength:     minlen_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (accept && en_q) begin
            state_q <= StFilt;
          end
        end
        StFilt: begin
          state_q <= StSqrt;
          sq_started_q <= 1'b0;
        end
        StSqrt: begin
          sq_started_q <= 1'b1;
          if (sq_done) begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= pos_new[i];
            end
            if (big) begin
              state_q <= StDiv;
            end else begin
              for (int i = 0; i < 3; i++) begin
                dir_q[i] <= dir_filt[i];
              end
              state_q <= StOut;
              out_valid_o <= 1'b1;
            end
          end
        end
        StDiv: begin
          if (div_done[0]) begin
            for (int i = 0; i < 3; i++) begin
              dir_q[i] <= dir_norm[i];
            end
            state_q <= StOut;
            out_valid_o <= 1'b1;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  assign out_data_o.light_pos_x = pos_q[0];
  assign out_data_o.light_pos_y = pos_q[1];
  assign out_data_o.light_pos_z = pos_q[2];
  assign out_data_o.light_dir_x = dir_q[0];
  assign out_data_o.light_dir_y = dir_q[1];
  assign out_data_o.light_dir_z = dir_q[2];

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut) else $error("result word outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done[0] == div_done[1] && div_done[1] == div_done[2])
    else $error("lane dividers out of step");

endmodule

// File: rtl/spf_lane.sv
// One component lane: position and direction filter steps and a serial divider
// for normalization. Depends on spf_pkg.
module spf_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spf_pkg::lane_ctrl_t  ctrl_i,
  input  logic signed [31:0]   pos_cur_i,
  input  logic signed [31:0]   pos_tgt_i,
  input  logic signed [15:0]   dir_cur_i,
  input  logic signed [15:0]   dir_tgt_i,
  input  logic [15:0]          pos_gain_i,
  input  logic [15:0]          dir_gain_i,
  input  logic [16:0]          len_i,
  output logic signed [31:0]   pos_new_o,
  output logic signed [15:0]   dir_filt_o,
  output logic signed [15:0]   dir_norm_o,
  output logic                 div_done_o
);

  logic signed [32:0] pos_diff;
  logic signed [49:0] pos_prod;
  logic signed [33:0] pos_step;
  logic signed [34:0] pos_sum;
  logic signed [16:0] dir_diff;
  logic signed [33:0] dir_prod;
  logic signed [17:0] dir_step;
  logic signed [18:0] dir_sum;

  logic [31:0] rem_q, rem_d;
  logic [31:0] num_q;
  logic [31:0] quo_q;
  logic [5:0]  cnt_q;
  logic        neg_q, busy_q;
  logic [32:0] trial;
  logic [15:0] mag;
  logic [32:0] num_init;
  logic        running;

  assign pos_diff = 33'(pos_tgt_i) - 33'(pos_cur_i);
  assign pos_prod = 50'(pos_diff) * $signed({34'd0, pos_gain_i});
  assign pos_step = 34'((pos_prod + 50'sd32768) >>> 16);
  assign pos_sum  = 35'(pos_cur_i) + 35'(pos_step);

  assign dir_diff = 17'(dir_tgt_i) - 17'(dir_cur_i);
  assign dir_prod = 34'(dir_diff) * $signed({18'd0, dir_gain_i});
  assign dir_step = 18'((dir_prod + 34'sd32768) >>> 16);
  assign dir_sum  = 19'(dir_cur_i) + 19'(dir_step);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.filt) begin
      if (pos_sum > 35'sd2147483647) begin
        pos_new_o <= 32'sh7fffffff;
      end else if (pos_sum < -35'sd2147483648) begin
        pos_new_o <= 32'sh80000000;
      end else begin
        pos_new_o <= pos_sum[31:0];
      end
      if (dir_sum > 19'sd32767) begin
        dir_filt_o <= 16'sh7fff;
      end else if (dir_sum < -19'sd32768) begin
        dir_filt_o <= 16'sh8000;
      end else begin
        dir_filt_o <= dir_sum[15:0];
      end
    end
  end

  assign mag      = dir_filt_o[15] ? 16'(-dir_filt_o) : dir_filt_o;
  assign num_init = {3'd0, mag, 14'd0} + {17'd0, len_i[16:1]};
  assign running  = busy_q && (cnt_q != 6'd0);
  assign trial    = {rem_q, num_q[31]} - {16'd0, len_i};
  assign rem_d    = trial[32] ? {rem_q[30:0], num_q[31]} : trial[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (ctrl_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (running) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      rem_q <= 32'd0;
      num_q <= num_init[31:0];
      quo_q <= 32'd0;
      neg_q <= dir_filt_o[15];
    end else if (running) begin
      rem_q <= rem_d;
      num_q <= {num_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ~trial[32]};
    end
  end

  assign div_done_o = busy_q && (cnt_q == 6'd0);

  always_comb begin
    if (neg_q) begin
      dir_norm_o = (quo_q > 32'd32768) ? 16'sh8000 : 16'(-quo_q[16:0]);
    end else begin
      dir_norm_o = (quo_q > 32'd32767) ? 16'sh7fff : quo_q[15:0];
    end
  end

endmodule

// File: rtl/spf_merge.sv
// Merging stage: sum of squares over the three direction lanes and a serial
// integer square root of that sum. Depends on no package.
module spf_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] dx_i,
  input  logic signed [15:0] dy_i,
  input  logic signed [15:0] dz_i,
  input  logic [14:0]        min_len_i,
  output logic               big_o,
  output logic [16:0]        len_o,
  output logic               done_o
);

  logic [31:0] sx_q, sy_q, sz_q;
  logic [33:0] sum;
  logic [33:0] val_q, res_q;
  logic [34:0] bit_q;
  logic [1:0]  ph_q;
  logic [4:0]  cnt_q;
  logic [34:0] trial;

  assign sum   = 34'(sx_q) + 34'(sy_q) + 34'(sz_q);
  assign trial = 35'(val_q) - (35'(res_q) + bit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= 2'd0;
      cnt_q <= 5'd0;
    end else if (start_i) begin
      ph_q <= 2'd1;
    end else if (ph_q == 2'd1) begin
      ph_q  <= 2'd2;
      cnt_q <= 5'd17;
    end else if (ph_q == 2'd2) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        ph_q <= 2'd3;
      end
    end else if (ph_q == 2'd3) begin
      ph_q <= 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sx_q <= 32'(dx_i) * 32'(dx_i);
      sy_q <= 32'(dy_i) * 32'(dy_i);
      sz_q <= 32'(dz_i) * 32'(dz_i);
    end else if (ph_q == 2'd1) begin
      val_q <= sum;
      res_q <= 34'd0;
      bit_q <= 35'd1 << 32;
      big_o <= sum > 34'(min_len_i) * 34'(min_len_i);
    end else if (ph_q == 2'd2) begin
      if (!trial[34]) begin
        val_q <= trial[33:0];
        res_q <= 34'((35'(res_q) >> 1) + bit_q);
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign len_o  = res_q[16:0];
  assign done_o = (ph_q == 2'd3);

endmodule

// File: tb/sv/smoothed_pose_follower_unit_test.sv
// Self-checking testbench for smoothed_pose_follower_unit: a queue-fed driver, a monitor and
// a cycle-free predictor of the smoothed pose. Depends on spf_pkg and the RTL top level.
module smoothed_pose_follower_unit_test;

  typedef struct {
    bit                          is_cfg;
    logic [spf_pkg::CfgIdxW-1:0] idx;
    logic [15:0]                 data;
    spf_pkg::in_word_t           w;
  } pending_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_stall;
  spf_pkg::in_word_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  spf_pkg::out_word_t          out_data;
  logic                        cfg_we;
  logic [spf_pkg::CfgIdxW-1:0] cfg_idx;
  logic [15:0]                 cfg_data;

  pending_t           pending_stimulus[$];
  spf_pkg::out_word_t expected_poses[$];
  int        fail_count = 0;
  int        words_sent = 0;
  int        poses_seen = 0;
  int        quiet_cycles = 0;

  bit        follow_en;
  longint    pos_gain, dir_gain, min_len;
  longint    smooth_pos[3];
  longint    smooth_dir[3];

  smoothed_pose_follower_unit i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint one_pole(longint cur, longint target, longint gain, int w);
    longint p;
    p = (target - cur) * gain + 32768;
    return clip(cur + (p >>> 16), w);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void follow_pose(spf_pkg::in_word_t w);
    longint tgt_pos[3], tgt_dir[3], s, mag, q;
    longint unsigned len;
    spf_pkg::out_word_t o;
    if (!follow_en) return;
    tgt_pos = '{w.target_pos_x, w.target_pos_y, w.target_pos_z};
    tgt_dir = '{w.target_dir_x, w.target_dir_y, w.target_dir_z};
    s = 0;
    for (int i = 0; i < 3; i++) begin
      smooth_pos[i] = one_pole(smooth_pos[i], tgt_pos[i], pos_gain, 32);
      smooth_dir[i] = one_pole(smooth_dir[i], tgt_dir[i], dir_gain, 16);
      s += smooth_dir[i] * smooth_dir[i];
    end
    if (s > min_len * min_len) begin
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
        mag = smooth_dir[i] < 0 ? -smooth_dir[i] : smooth_dir[i];
        q = (mag * 16384 + longint'(len / 2)) / longint'(len);
        smooth_dir[i] = clip(smooth_dir[i] < 0 ? -q : q, 16);
      end
    end
    o.light_pos_x = smooth_pos[0][31:0];
    o.light_pos_y = smooth_pos[1][31:0];
    o.light_pos_z = smooth_pos[2][31:0];
    o.light_dir_x = smooth_dir[0][15:0];
    o.light_dir_y = smooth_dir[1][15:0];
    o.light_dir_z = smooth_dir[2][15:0];
    expected_poses.push_back(o);
  endfunction

  function automatic void apply_register(logic [spf_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    case (idx)
      spf_pkg::RegFollowEnable:  follow_en = data[0];
      spf_pkg::RegPositionGain:  pos_gain = data;
      spf_pkg::RegDirectionGain: dir_gain = data;
      spf_pkg::RegMinLength:     min_len = data[14:0];
      default: ;
    endcase
  endfunction

  task automatic add_word(longint px, longint py, longint pz, longint dx, longint dy,
                          longint dz);
    pending_t p;
    p.is_cfg = 0;
    p.idx = '0;
    p.data = '0;
    p.w = '{px[31:0], py[31:0], pz[31:0], dx[15:0], dy[15:0], dz[15:0]};
    pending_stimulus.push_back(p);
  endtask

  task automatic add_cfg(logic [spf_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
    pending_t p;
    p.is_cfg = 1;
    p.idx = idx;
    p.data = data;
    p.w = '0;
    pending_stimulus.push_back(p);
  endtask

  task automatic add_random_word();
    longint pv[3], dv[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: pv[i] = longint'($signed($urandom()));
        1: pv[i] = longint'($urandom_range(65535)) - 32768;
        2: pv[i] = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
        default: pv[i] = longint'($signed($urandom())) >>> $urandom_range(31);
      endcase
      case ($urandom_range(3))
        0: dv[i] = longint'($signed(16'($urandom())));
        1: dv[i] = longint'($urandom_range(64)) - 32;
        2: dv[i] = $urandom_range(1) ? 32767 : -32768;
        default: dv[i] = longint'($urandom_range(32768)) - 16384;
      endcase
    end
    add_word(pv[0], pv[1], pv[2], dv[0], dv[1], dv[2]);
  endtask

  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s expected %0d got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit       nv, nwe, calm;
    pending_t p;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      cfg_we <= 1'b0;
      cfg_idx <= '0;
      cfg_data <= '0;
    end else begin
      nv = in_valid;
      nwe = 0;
      if (in_valid && !in_stall) begin
        follow_pose(in_data);
        quiet_cycles = 0;
        nv = 0;
      end else if (quiet_cycles < 1000) begin
        quiet_cycles++;
      end
      calm = words_sent >= 400 && words_sent < 560;
      if (!nv && pending_stimulus.size() > 0) begin
        if (pending_stimulus[0].is_cfg) begin
          if (expected_poses.size() == 0 && quiet_cycles >= 100) begin
            p = pending_stimulus.pop_front();
            apply_register(p.idx, p.data);
            cfg_idx <= p.idx;
            cfg_data <= p.data;
            nwe = 1;
          end
        end else if (calm || $urandom_range(99) >= 29) begin
          p = pending_stimulus.pop_front();
          in_data <= p.w;
          words_sent++;
          nv = 1;
        end
      end
      in_valid <= nv;
      cfg_we <= nwe;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    spf_pkg::out_word_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        poses_seen++;
        if (expected_poses.size() == 0) begin
          $error("unexpected result word %h", out_data);
          fail_count++;
        end else begin
          e = expected_poses.pop_front();
          check_field("light_pos_x", e.light_pos_x, out_data.light_pos_x);
          check_field("light_pos_y", e.light_pos_y, out_data.light_pos_y);
          check_field("light_pos_z", e.light_pos_z, out_data.light_pos_z);
          check_field("light_dir_x", e.light_dir_x, out_data.light_dir_x);
          check_field("light_dir_y", e.light_dir_y, out_data.light_dir_y);
          check_field("light_dir_z", e.light_dir_z, out_data.light_dir_z);
        end
      end
      out_stall <= !(poses_seen >= 400 && poses_seen < 560) && $urandom_range(99) < 29;
    end
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    follow_en = 1;
    pos_gain = spf_pkg::PosGainReset;
    dir_gain = spf_pkg::DirGainReset;
    min_len = spf_pkg::MinLenReset;
    smooth_pos = '{spf_pkg::PosXReset, spf_pkg::PosYReset, spf_pkg::PosZReset};
    smooth_dir = '{spf_pkg::DirXReset, spf_pkg::DirYReset, spf_pkg::DirZReset};

    add_word(0, 0, 0, 0, 0, 0);
    add_word(2147483647, -64'sd2147483648, 2147483647, 32767, -32768, 32767);
    add_word(-64'sd2147483648, 2147483647, -64'sd2147483648, -32768, 32767, -32768);
    add_cfg(spf_pkg::RegPositionGain, 16'hFFFF);
    add_cfg(spf_pkg::RegDirectionGain, 16'hFFFF);
    add_word(2147483647, 2147483647, -64'sd2147483648, 32767, 32767, 32767);
    add_word(-64'sd2147483648, -64'sd2147483648, 2147483647, -32768, -32768, -32768);
    add_cfg(spf_pkg::RegMinLength, 16'h0000);
    add_word(0, 0, 0, 0, 0, 0);
    add_word(0, 0, 0, 0, 0, 0);
    add_word(0, 0, 0, 0, 0, 0);
    add_cfg(spf_pkg::RegMinLength, 16'hFFFF);
    add_word(65536, -65536, 1, 100, -200, 50);
    add_word(1, 1, 1, 32767, 0, 0);
    add_cfg(spf_pkg::RegPositionGain, 16'h0000);
    add_cfg(spf_pkg::RegDirectionGain, 16'h0000);
    add_word(123456, -654321, 42, 1000, 2000, -3000);
    add_cfg(spf_pkg::RegFollowEnable, 16'hFFFE);
    add_word(5, 6, 7, 8, 9, 10);
    add_word(-5, -6, -7, -8, -9, -10);
    add_cfg(spf_pkg::RegFollowEnable, 16'h0001);
    add_cfg(spf_pkg::RegPositionGain, 16'h8000);
    add_cfg(spf_pkg::RegDirectionGain, 16'h8000);
    add_cfg(spf_pkg::RegMinLength, 16'h8010);
    add_word(-1, -1, -1, -1, -1, -1);
    add_word(32768, -32768, 0, 16384, 0, -16384);

    for (int ph = 0; ph < 7; ph++) begin
      add_cfg(spf_pkg::RegFollowEnable,
              16'($urandom_range(65535)) | (ph == 3 ? 16'h0 : 16'h1));
      add_cfg(spf_pkg::RegPositionGain,
              ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0001 : 16'($urandom()));
      add_cfg(spf_pkg::RegDirectionGain,
              ph == 0 ? 16'hFFFF : ph == 2 ? 16'h0000 : 16'($urandom()));
      add_cfg(spf_pkg::RegMinLength,
              ph == 4 ? 16'h7FFF : ph == 5 ? 16'h0000 : 16'($urandom()));
      for (int n = 0; n < (ph == 3 ? 30 : 170); n++) add_random_word();
    end

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_stimulus.size() != 0 || in_valid || expected_poses.size() != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && expected_poses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/spf_pkg.sv
rtl/spf_lane.sv
rtl/spf_merge.sv
rtl/smoothed_pose_follower_unit.sv
tb/sv/smoothed_pose_follower_unit_test.sv
